// ----- design/rop_pkg.sv -----
// Shared types and constants for the offset-point kinematics block.
// Holds datapath commands, status, operand sources and code values.
// No dependencies.
package rop_pkg;

    // Fixed-point and sizing constants independent of the data width
    localparam int ROT_FRAC = 20;   // fraction bits of rotation entries
    localparam int QN_W     = 22;   // signed normalized quaternion part
    localparam int PQ_W     = 44;   // quaternion product
    localparam int NE_W     = 46;   // signed quadratic-form entry
    localparam int N2_W     = 44;   // squared norm and divider remainder
    localparam int ROT_W    = 22;   // signed rotation entry
    localparam int QBITS    = 21;   // divider quotient bits
    localparam int NUM_W    = 68;   // divider dividend
    localparam int OP_W     = 3;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Input item op codes
    localparam logic [OP_W-1:0] OP_POSE = 3'd0;
    localparam logic [OP_W-1:0] OP_VEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_ACC  = 3'd2;
    localparam logic [OP_W-1:0] OP_ANGV = 3'd3;
    localparam logic [OP_W-1:0] OP_ANGA = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_POS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACC = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_NORM_INIT,
        DP_SHR,
        DP_SHL,
        DP_ROT_IDENT,
        DP_QMUL,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_DONE,
        DP_MUL,
        DP_ACC,
        DP_RND_C1,
        DP_RND_C2,
        DP_RND_RES
    } t_dp_op;

    typedef enum logic [2:0] {
        SRC_QN,
        SRC_W,
        SRC_AL,
        SRC_D,
        SRC_C1,
        SRC_C2,
        SRC_ROT
    } t_src;

    typedef struct packed {
        t_dp_op              op;
        t_src                a_src;
        logic [3:0]          a_idx;
        t_src                b_src;
        logic [3:0]          b_idx;
        logic                neg;
        logic                first;
        logic [KIND_W-1:0]   kind;
        logic [3:0]          idx;
    } t_cmd;

    typedef struct packed {
        logic q_zero;
        logic q_hi;
        logic q_lo;
    } t_sts;

endpackage

// ----- design/rop_in_if.sv -----
// Input item channel: valid/ready handshake plus op, vector and quaternion.
// Depends on rop_pkg.
interface rop_in_if #(parameter int DATA_WIDTH = 32);
    import rop_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              op;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;

    modport source (output valid, op, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink   (input valid, op, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                    output ready);
endinterface

// ----- design/rop_out_if.sv -----
// Result item channel: valid/ready handshake plus kind, vector and orientation.
// Depends on rop_pkg.
interface rop_out_if #(parameter int DATA_WIDTH = 32);
    import rop_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [KIND_W-1:0]            kind;
    logic signed [DATA_WIDTH-1:0] res_x;
    logic signed [DATA_WIDTH-1:0] res_y;
    logic signed [DATA_WIDTH-1:0] res_z;
    logic signed [DATA_WIDTH-1:0] orient_w;
    logic signed [DATA_WIDTH-1:0] orient_x;
    logic signed [DATA_WIDTH-1:0] orient_y;
    logic signed [DATA_WIDTH-1:0] orient_z;
    logic                         last;

    modport source (output valid, kind, res_x, res_y, res_z, orient_w, orient_x, orient_y,
                    orient_z, last, input ready);
    modport sink   (input valid, kind, res_x, res_y, res_z, orient_w, orient_x, orient_y,
                    orient_z, last, output ready);
endinterface

// ----- design/rop_ctrl.sv -----
// Sequencer for the offset-point kinematics block: marks, phases, counters.
// Issues datapath commands; depends on rop_pkg.
module rop_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [rop_pkg::OP_W-1:0]      i_in_op,
    output logic                          o_in_ready,
    input  rop_pkg::t_sts                 i_sts,
    output rop_pkg::t_cmd                 o_cmd,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rop_pkg::KIND_W-1:0]    o_kind
);
    import rop_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_QMUL, S_DIV_INIT, S_DIV_STEP, S_DIV_DONE,
        S_X1, S_RND1, S_X2, S_RND2, S_ROT, S_RNDR, S_EMIT
    } t_state;

    t_state            r_state;
    logic [4:0]        r_marks;
    logic [3:0]        r_cnt;
    logic [1:0]        r_term;
    logic [KIND_W-1:0] r_kind;
    logic [4:0]        r_step;
    logic              r_ph;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_store;
    logic              w_tick;
    logic [3:0]        w_ia;    // (cnt+1) mod 3
    logic [3:0]        w_ib;    // (cnt+2) mod 3
    t_cmd              w_cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_store     = (i_in_op <= OP_ANGA);
    assign w_tick      = (i_in_op == OP_TICK) && (&r_marks);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_cmd       = w_cmd;

    // cyclic neighbors of the current component
    always_comb begin
        case (r_cnt)
            4'd0:    begin w_ia = 4'd1; w_ib = 4'd2; end
            4'd1:    begin w_ia = 4'd2; w_ib = 4'd0; end
            default: begin w_ia = 4'd0; w_ib = 4'd1; end
        endcase
    end

    // command decode
    always_comb begin
        w_cmd       = '0;
        w_cmd.op    = DP_NOP;
        w_cmd.idx   = r_cnt;
        w_cmd.kind  = r_kind;
        w_cmd.first = (r_term == 2'd0);
        w_cmd.a_src = SRC_QN;
        w_cmd.b_src = SRC_QN;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_store) begin
                    w_cmd.op = DP_LOAD;
                end else if (w_accept && w_tick) begin
                    w_cmd.op = DP_NORM_INIT;
                end
            end
            S_NORM: begin
                if (i_sts.q_zero) begin
                    w_cmd.op = DP_ROT_IDENT;
                end else if (i_sts.q_hi) begin
                    w_cmd.op = DP_SHR;
                end else if (i_sts.q_lo) begin
                    w_cmd.op = DP_SHL;
                end
            end
            S_QMUL: begin
                // ww xx yy zz xy wz xz wy yz wx
                w_cmd.op = DP_QMUL;
                case (r_cnt)
                    4'd0:    begin w_cmd.a_idx = 4'd0; w_cmd.b_idx = 4'd0; end
                    4'd1:    begin w_cmd.a_idx = 4'd1; w_cmd.b_idx = 4'd1; end
                    4'd2:    begin w_cmd.a_idx = 4'd2; w_cmd.b_idx = 4'd2; end
                    4'd3:    begin w_cmd.a_idx = 4'd3; w_cmd.b_idx = 4'd3; end
                    4'd4:    begin w_cmd.a_idx = 4'd1; w_cmd.b_idx = 4'd2; end
                    4'd5:    begin w_cmd.a_idx = 4'd0; w_cmd.b_idx = 4'd3; end
                    4'd6:    begin w_cmd.a_idx = 4'd1; w_cmd.b_idx = 4'd3; end
                    4'd7:    begin w_cmd.a_idx = 4'd0; w_cmd.b_idx = 4'd2; end
                    4'd8:    begin w_cmd.a_idx = 4'd2; w_cmd.b_idx = 4'd3; end
                    default: begin w_cmd.a_idx = 4'd0; w_cmd.b_idx = 4'd1; end
                endcase
            end
            S_DIV_INIT: w_cmd.op = DP_DIV_INIT;
            S_DIV_STEP: w_cmd.op = DP_DIV_STEP;
            S_DIV_DONE: w_cmd.op = DP_DIV_DONE;
            S_X1: begin
                // w x d
                w_cmd.op    = r_ph ? DP_ACC : DP_MUL;
                w_cmd.a_src = SRC_W;
                w_cmd.b_src = SRC_D;
                w_cmd.neg   = r_term[0];
                w_cmd.a_idx = r_term[0] ? w_ib : w_ia;
                w_cmd.b_idx = r_term[0] ? w_ia : w_ib;
            end
            S_X2: begin
                // alpha x d + w x c1
                w_cmd.op    = r_ph ? DP_ACC : DP_MUL;
                w_cmd.a_src = r_term[1] ? SRC_W : SRC_AL;
                w_cmd.b_src = r_term[1] ? SRC_C1 : SRC_D;
                w_cmd.neg   = r_term[0];
                w_cmd.a_idx = r_term[0] ? w_ib : w_ia;
                w_cmd.b_idx = r_term[0] ? w_ia : w_ib;
            end
            S_ROT: begin
                w_cmd.op    = r_ph ? DP_ACC : DP_MUL;
                w_cmd.a_src = SRC_ROT;
                w_cmd.a_idx = {r_cnt[2:0], 1'b0} + r_cnt + {2'b00, r_term};
                w_cmd.b_idx = {2'b00, r_term};
                case (r_kind)
                    KIND_POS: w_cmd.b_src = SRC_D;
                    KIND_VEL: w_cmd.b_src = SRC_C1;
                    default:  w_cmd.b_src = SRC_C2;
                endcase
            end
            S_RND1: w_cmd.op = DP_RND_C1;
            S_RND2: w_cmd.op = DP_RND_C2;
            S_RNDR: w_cmd.op = DP_RND_RES;
            default: w_cmd.op = DP_NOP;
        endcase
    end

    // state, counters and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_marks     <= '0;
            r_cnt       <= '0;
            r_term      <= '0;
            r_kind      <= KIND_POS;
            r_step      <= '0;
            r_ph        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_store) begin
                        r_marks[i_in_op] <= 1'b1;
                    end else if (w_accept && w_tick) begin
                        r_state <= S_NORM;
                        r_cnt   <= '0;
                        r_term  <= '0;
                        r_ph    <= 1'b0;
                        r_kind  <= KIND_POS;
                    end
                end
                S_NORM: begin
                    if (i_sts.q_zero) begin
                        r_state <= S_X1;
                    end else if (!i_sts.q_hi && !i_sts.q_lo) begin
                        r_state <= S_QMUL;
                    end
                end
                S_QMUL: begin
                    if (r_cnt == 4'd9) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV_INIT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DIV_INIT: begin
                    r_step  <= '0;
                    r_state <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    if (r_step == 5'(QBITS - 1)) begin
                        r_state <= S_DIV_DONE;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_DIV_DONE: begin
                    if (r_cnt == 4'd8) begin
                        r_cnt   <= '0;
                        r_state <= S_X1;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_X1: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_term == 2'd1) begin
                            r_term  <= '0;
                            r_state <= S_RND1;
                        end else begin
                            r_term <= r_term + 2'd1;
                        end
                    end
                end
                S_RND1: begin
                    if (r_cnt == 4'd2) begin
                        r_cnt   <= '0;
                        r_state <= S_X2;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= S_X1;
                    end
                end
                S_X2: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_term == 2'd3) begin
                            r_term  <= '0;
                            r_state <= S_RND2;
                        end else begin
                            r_term <= r_term + 2'd1;
                        end
                    end
                end
                S_RND2: begin
                    if (r_cnt == 4'd2) begin
                        r_cnt   <= '0;
                        r_kind  <= KIND_POS;
                        r_state <= S_ROT;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= S_X2;
                    end
                end
                S_ROT: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_term == 2'd2) begin
                            r_term  <= '0;
                            r_state <= S_RNDR;
                        end else begin
                            r_term <= r_term + 2'd1;
                        end
                    end
                end
                S_RNDR: begin
                    if (r_cnt == 4'd2) begin
                        r_cnt       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= S_ROT;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_kind == KIND_ACC) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_kind  <= r_kind + 2'd1;
                            r_state <= S_ROT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/rop_datapath.sv -----
// Datapath: stored body state, offset registers, shared multiplier and
// accumulator, quaternion normalizer and bit-serial divider. Depends on rop_pkg.
module rop_datapath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rop_pkg::t_cmd                     i_cmd,
    input  logic [rop_pkg::OP_W-1:0]          i_op,
    input  logic signed [DATA_WIDTH-1:0]      i_vec_x,
    input  logic signed [DATA_WIDTH-1:0]      i_vec_y,
    input  logic signed [DATA_WIDTH-1:0]      i_vec_z,
    input  logic signed [DATA_WIDTH-1:0]      i_quat_w,
    input  logic signed [DATA_WIDTH-1:0]      i_quat_x,
    input  logic signed [DATA_WIDTH-1:0]      i_quat_y,
    input  logic signed [DATA_WIDTH-1:0]      i_quat_z,
    input  logic                              i_cfg_we,
    input  logic [rop_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]             i_cfg_data,
    output rop_pkg::t_sts                     o_sts,
    output logic signed [DATA_WIDTH-1:0]      o_res_x,
    output logic signed [DATA_WIDTH-1:0]      o_res_y,
    output logic signed [DATA_WIDTH-1:0]      o_res_z,
    output logic signed [DATA_WIDTH-1:0]      o_quat_w,
    output logic signed [DATA_WIDTH-1:0]      o_quat_x,
    output logic signed [DATA_WIDTH-1:0]      o_quat_y,
    output logic signed [DATA_WIDTH-1:0]      o_quat_z
);
    import rop_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int QW    = (DW > 21) ? DW : 21;     // magnitude during normalization
    localparam int MW    = (DW > QN_W) ? DW : QN_W; // multiplier operand
    localparam int ACC_W = 2 * MW + 2;
    localparam longint OFFX_RST = ((longint'(9) << FRAC_BITS) + 50) / 100;
    localparam longint OFFZ_RST = ((longint'(85) << FRAC_BITS) + 500) / 1000;

    // stored body state and offsets
    logic signed [DW-1:0] r_pos [3];
    logic signed [DW-1:0] r_vel [3];
    logic signed [DW-1:0] r_acc [3];
    logic signed [DW-1:0] r_w   [3];
    logic signed [DW-1:0] r_al  [3];
    logic signed [DW-1:0] r_quat[4];
    logic signed [DW-1:0] r_d   [3];
    logic signed [DW-1:0] r_c1  [3];
    logic signed [DW-1:0] r_c2  [3];
    logic signed [DW-1:0] r_res [3];

    // normalization, rotation and arithmetic registers
    logic [QW-1:0]            r_qm [4];
    logic                     r_qs [4];
    logic signed [PQ_W-1:0]   r_pq [10];
    logic signed [ROT_W-1:0]  r_rot[9];
    logic signed [2*MW-1:0]   r_prod;
    logic                     r_pneg;
    logic signed [ACC_W-1:0]  r_accum;
    logic [N2_W-1:0]          r_rem;
    logic [QBITS-1:0]         r_quo;
    logic                     r_dneg;

    logic signed [QN_W-1:0]   w_qn [4];
    logic [QW-1:0]            w_max01;
    logic [QW-1:0]            w_max23;
    logic [QW-1:0]            w_max;
    logic signed [MW-1:0]     w_opa;
    logic signed [MW-1:0]     w_opb;
    logic signed [2*MW-1:0]   w_mul;
    logic signed [NE_W-1:0]   w_e [10];
    logic signed [NE_W-1:0]   w_ne;
    logic [NE_W-1:0]          w_nabs;
    logic [N2_W-1:0]          w_n2;
    logic [NUM_W-1:0]         w_num;
    logic [N2_W:0]            w_trial;
    logic                     w_qbit;
    logic signed [ROT_W-1:0]  w_q;
    logic signed [DW-1:0]     w_base;
    logic signed [ACC_W-1:0]  w_init;
    logic signed [ACC_W-1:0]  w_add;

    function automatic logic [DW-1:0] f_mag(input logic signed [DW-1:0] v);
        f_mag = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // round to nearest, ties away from zero, and saturate to DW bits
    function automatic logic signed [DW-1:0] f_round(input logic signed [ACC_W-1:0] a,
                                                     input logic rot);
        logic             neg;
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] q;
        logic [ACC_W-1:0] lim;
        neg = a[ACC_W-1];
        m   = neg ? ACC_W'(-a) : ACC_W'(a);
        if (rot) begin
            q = (m + (ACC_W'(1) << (ROT_FRAC - 1))) >> ROT_FRAC;
        end else begin
            q = (m + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        end
        lim = neg ? (ACC_W'(1) << (DW - 1)) : ((ACC_W'(1) << (DW - 1)) - ACC_W'(1));
        if (q > lim) begin
            q = lim;
        end
        f_round = neg ? DW'(-q) : DW'(q);
    endfunction

    // signed normalized quaternion parts and largest magnitude
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_qn[i] = r_qs[i] ? -$signed({1'b0, r_qm[i][QN_W-2:0]})
                              : $signed({1'b0, r_qm[i][QN_W-2:0]});
        end
    end
    assign w_max01 = (r_qm[0] > r_qm[1]) ? r_qm[0] : r_qm[1];
    assign w_max23 = (r_qm[2] > r_qm[3]) ? r_qm[2] : r_qm[3];
    assign w_max   = (w_max01 > w_max23) ? w_max01 : w_max23;
    assign o_sts.q_zero = (w_max == '0);
    assign o_sts.q_hi   = |w_max[QW-1:20];
    assign o_sts.q_lo   = ~|w_max[QW-1:19];

    // operand A select
    always_comb begin
        case (i_cmd.a_src)
            SRC_QN:  w_opa = MW'(w_qn[i_cmd.a_idx[1:0]]);
            SRC_W:   w_opa = MW'(r_w[i_cmd.a_idx[1:0]]);
            SRC_AL:  w_opa = MW'(r_al[i_cmd.a_idx[1:0]]);
            SRC_ROT: w_opa = MW'(r_rot[i_cmd.a_idx]);
            default: w_opa = '0;
        endcase
    end

    // operand B select
    always_comb begin
        case (i_cmd.b_src)
            SRC_QN:  w_opb = MW'(w_qn[i_cmd.b_idx[1:0]]);
            SRC_D:   w_opb = MW'(r_d[i_cmd.b_idx[1:0]]);
            SRC_C1:  w_opb = MW'(r_c1[i_cmd.b_idx[1:0]]);
            SRC_C2:  w_opb = MW'(r_c2[i_cmd.b_idx[1:0]]);
            default: w_opb = '0;
        endcase
    end

    // the shared multiplier
    assign w_mul = w_opa * w_opb;

    // quadratic-form entries from the products ww xx yy zz xy wz xz wy yz wx
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            w_e[i] = NE_W'(r_pq[i]);
        end
        case (i_cmd.idx)
            4'd0:    w_ne = w_e[0] + w_e[1] - w_e[2] - w_e[3];
            4'd1:    w_ne = (w_e[4] - w_e[5]) <<< 1;
            4'd2:    w_ne = (w_e[6] + w_e[7]) <<< 1;
            4'd3:    w_ne = (w_e[4] + w_e[5]) <<< 1;
            4'd4:    w_ne = w_e[0] - w_e[1] + w_e[2] - w_e[3];
            4'd5:    w_ne = (w_e[8] - w_e[9]) <<< 1;
            4'd6:    w_ne = (w_e[6] - w_e[7]) <<< 1;
            4'd7:    w_ne = (w_e[8] + w_e[9]) <<< 1;
            default: w_ne = w_e[0] - w_e[1] - w_e[2] + w_e[3];
        endcase
    end
    assign w_n2    = N2_W'(w_e[0] + w_e[1] + w_e[2] + w_e[3]);
    assign w_nabs  = w_ne[NE_W-1] ? NE_W'(-w_ne) : NE_W'(w_ne);
    assign w_num   = (NUM_W'(w_nabs) << ROT_FRAC) + NUM_W'(w_n2 >> 1);
    assign w_trial = {r_rem, r_quo[QBITS-1]};
    assign w_qbit  = (w_trial >= {1'b0, w_n2});
    assign w_q     = $signed({1'b0, r_quo});

    // accumulator start value: the base vector for a rotation row, zero for other first terms
    always_comb begin
        case (i_cmd.kind)
            KIND_POS: w_base = r_pos[i_cmd.idx[1:0]];
            KIND_VEL: w_base = r_vel[i_cmd.idx[1:0]];
            default:  w_base = r_acc[i_cmd.idx[1:0]];
        endcase
        if (!i_cmd.first) begin
            w_init = r_accum;
        end else if (i_cmd.a_src == SRC_ROT) begin
            w_init = ACC_W'(w_base) <<< ROT_FRAC;
        end else begin
            w_init = '0;
        end
        w_add = r_pneg ? -ACC_W'(r_prod) : ACC_W'(r_prod);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d[0] <= DW'(OFFX_RST);
            r_d[1] <= '0;
            r_d[2] <= DW'(OFFZ_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFF_X: r_d[0] <= i_cfg_data;
                CFG_OFF_Y: r_d[1] <= i_cfg_data;
                CFG_OFF_Z: r_d[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // command execution
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                case (i_op)
                    OP_POSE: begin
                        r_pos[0]  <= i_vec_x;  r_pos[1]  <= i_vec_y;  r_pos[2]  <= i_vec_z;
                        r_quat[0] <= i_quat_w; r_quat[1] <= i_quat_x;
                        r_quat[2] <= i_quat_y; r_quat[3] <= i_quat_z;
                    end
                    OP_VEL: begin
                        r_vel[0] <= i_vec_x; r_vel[1] <= i_vec_y; r_vel[2] <= i_vec_z;
                    end
                    OP_ACC: begin
                        r_acc[0] <= i_vec_x; r_acc[1] <= i_vec_y; r_acc[2] <= i_vec_z;
                    end
                    OP_ANGV: begin
                        r_w[0] <= i_vec_x; r_w[1] <= i_vec_y; r_w[2] <= i_vec_z;
                    end
                    OP_ANGA: begin
                        r_al[0] <= i_vec_x; r_al[1] <= i_vec_y; r_al[2] <= i_vec_z;
                    end
                    default: ;
                endcase
            end
            DP_NORM_INIT: begin
                for (int i = 0; i < 4; i++) begin
                    r_qm[i] <= QW'(f_mag(r_quat[i]));
                    r_qs[i] <= r_quat[i][DW-1];
                end
            end
            DP_SHR: begin
                for (int i = 0; i < 4; i++) begin
                    r_qm[i] <= r_qm[i] >> 1;
                end
            end
            DP_SHL: begin
                for (int i = 0; i < 4; i++) begin
                    r_qm[i] <= r_qm[i] << 1;
                end
            end
            DP_ROT_IDENT: begin
                for (int k = 0; k < 9; k++) begin
                    r_rot[k] <= (k % 4 == 0) ? (ROT_W'(1) << ROT_FRAC) : '0;
                end
            end
            DP_QMUL: r_pq[i_cmd.idx] <= PQ_W'(w_mul);
            DP_DIV_INIT: begin
                r_rem  <= N2_W'(w_num >> QBITS);
                r_quo  <= w_num[QBITS-1:0];
                r_dneg <= w_ne[NE_W-1];
            end
            DP_DIV_STEP: begin
                r_rem <= w_qbit ? N2_W'(w_trial - {1'b0, w_n2}) : N2_W'(w_trial);
                r_quo <= {r_quo[QBITS-2:0], w_qbit};
            end
            DP_DIV_DONE: r_rot[i_cmd.idx] <= r_dneg ? -w_q : w_q;
            DP_MUL: begin
                r_prod <= w_mul;
                r_pneg <= i_cmd.neg;
            end
            DP_ACC:     r_accum <= w_init + w_add;
            DP_RND_C1:  r_c1[i_cmd.idx[1:0]]  <= f_round(r_accum, 1'b0);
            DP_RND_C2:  r_c2[i_cmd.idx[1:0]]  <= f_round(r_accum, 1'b0);
            DP_RND_RES: r_res[i_cmd.idx[1:0]] <= f_round(r_accum, 1'b1);
            default: ;
        endcase
    end

    assign o_res_x  = r_res[0];
    assign o_res_y  = r_res[1];
    assign o_res_z  = r_res[2];
    assign o_quat_w = r_quat[0];
    assign o_quat_x = r_quat[1];
    assign o_quat_y = r_quat[2];
    assign o_quat_z = r_quat[3];

endmodule

// ----- design/rigid_offset_point_kinematics.sv -----
// Store items (pose, velocity, acceleration, angular velocity, angular acceleration) are
// stored while idle. A compute tick with all five stored yields three result items, position,
// velocity and acceleration of the offset point, in that order; the last one has last set.
// A tick runs these steps, stalled further by output back-pressure: one-bit quaternion
// shifts for normalization, 10 quaternion products, nine bit-serial divisions for the
// rotation entries, then multiply-accumulate terms on one shared multiplier (6+12 for
// the cross products, 27 for the rotations) with a rounding step per component.
// A zero quaternion skips the divider and uses the identity. One item is processed at a
// time; the input is not ready until the last result of a tick has been taken.
// Depends on rop_pkg, rop_in_if, rop_out_if, rop_ctrl and rop_datapath.
module rigid_offset_point_kinematics #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rop_in_if.sink                            i_item,
    rop_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [rop_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]             i_cfg_data
);
    import rop_pkg::*;

    t_cmd                     w_cmd;
    t_sts                     w_sts;
    logic                     w_out_valid;
    logic [KIND_W-1:0]        w_kind;
    logic signed [DATA_WIDTH-1:0] w_res_x, w_res_y, w_res_z;
    logic signed [DATA_WIDTH-1:0] w_quat_w, w_quat_x, w_quat_y, w_quat_z;

    rop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_op     (i_item.op),
        .o_in_ready  (i_item.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .o_kind      (w_kind)
    );

    rop_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (i_item.op),
        .i_vec_x    (i_item.vec_x),
        .i_vec_y    (i_item.vec_y),
        .i_vec_z    (i_item.vec_z),
        .i_quat_w   (i_item.quat_w),
        .i_quat_x   (i_item.quat_x),
        .i_quat_y   (i_item.quat_y),
        .i_quat_z   (i_item.quat_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sts      (w_sts),
        .o_res_x    (w_res_x),
        .o_res_y    (w_res_y),
        .o_res_z    (w_res_z),
        .o_quat_w   (w_quat_w),
        .o_quat_x   (w_quat_x),
        .o_quat_y   (w_quat_y),
        .o_quat_z   (w_quat_z)
    );

    // result item; orientation only rides on the position result
    assign o_res.valid    = w_out_valid;
    assign o_res.kind     = w_kind;
    assign o_res.res_x    = w_res_x;
    assign o_res.res_y    = w_res_y;
    assign o_res.res_z    = w_res_z;
    assign o_res.orient_w = (w_kind == KIND_POS) ? w_quat_w : '0;
    assign o_res.orient_x = (w_kind == KIND_POS) ? w_quat_x : '0;
    assign o_res.orient_y = (w_kind == KIND_POS) ? w_quat_y : '0;
    assign o_res.orient_z = (w_kind == KIND_POS) ? w_quat_z : '0;
    assign o_res.last     = (w_kind == KIND_ACC);

`ifndef SYNTH
    // no new item is taken while a result is pending
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_item.ready)
        else $error("input ready while a result is pending");

    // after the last result of a tick the block is ready again
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last) |=> i_item.ready)
        else $error("block not ready after last result");

    // velocity and acceleration results carry no orientation
    a_orient_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind != KIND_POS)) |->
        (o_res.orient_w == '0 && o_res.orient_x == '0 &&
         o_res.orient_y == '0 && o_res.orient_z == '0))
        else $error("orientation on a non-position result");
`endif

endmodule
